>>> rtl/core/ackermann_wheel_angle_split_defines.svh
// Assertion macros for the port checker of the wheel angle split block.
`ifndef ACKERMANN_WHEEL_ANGLE_SPLIT_DEFINES_SVH
`define ACKERMANN_WHEEL_ANGLE_SPLIT_DEFINES_SVH

// Checked at every rising edge outside reset.
`define AWAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define AWAS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/awas_pkg.sv
// Types, constants and the arctangent table of the wheel angle split block.
`default_nettype none
package awas_pkg;
  localparam int ANGLE_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 8;
  localparam int ROT_W = 34;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_TRACK = 8'd1;

  localparam logic signed [ROT_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ROT_W-1:0] CORDIC_X0 = 34'sd536870912;

  typedef struct packed {
    logic [ANGLE_W-1:0] raw;
    logic bypass;
    logic ok;
    logic neg_l;
    logic neg_r;
    logic dz_l;
    logic dz_r;
  } side_t;

  function automatic logic signed [ROT_W-1:0] atan_lut(input int i);
    logic signed [ROT_W-1:0] r;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/ackermann_wheel_angle_split.sv
// Top level of the Ackermann wheel angle split pipeline.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  angle    | angle_valid/angle_stall | center_angle
//  wheel    | wheel_valid/wheel_stall | left_angle, right_angle, result_valid
//  cfg      | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// One transfer is taken per cycle unless wheel_stall backs up the pipeline. Samples
// pass the rotation CORDIC, two multiply stages and the vectoring CORDIC in a row.
// Reset clears the valid bits and both length registers; cfg_ready stays high.
// A stall holds only the stages that hold data, so bubbles close up behind it.
`default_nettype none
module ackermann_wheel_angle_split #(
  parameter int ANGLE_FRAC_BITS = 14,
  parameter int LENGTH_WIDTH = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic angle_valid,
  output logic angle_stall,
  input  wire logic signed [awas_pkg::ANGLE_W-1:0] center_angle,
  output logic wheel_valid,
  input  wire logic wheel_stall,
  output logic signed [awas_pkg::ANGLE_W-1:0] left_angle,
  output logic signed [awas_pkg::ANGLE_W-1:0] right_angle,
  output logic result_valid,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [awas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [awas_pkg::CFG_DATA_W-1:0] cfg_data
);
  import awas_pkg::*;

  localparam int N = CORDIC_STAGES;
  localparam int NS = 2 * N + 4;
  localparam int QS = 30 - ANGLE_FRAC_BITS;
  localparam int VW = LENGTH_WIDTH + ROT_W + 5;
  localparam logic signed [ROT_W-1:0] LIMIT = HALF_PI_Q30 >>> QS;
  localparam logic signed [ROT_W-1:0] ROUND = ROT_W'(1) <<< (QS - 1);
  localparam logic signed [ROT_W-1:0] RIGHT_ANGLE = (HALF_PI_Q30 + ROUND) >>> QS;

  logic [LENGTH_WIDTH-1:0] wheel_base_mm, wheel_track_mm;
  logic [NS-1:0] v, en;

  logic signed [ROT_W-1:0] rx [0:N];
  logic signed [ROT_W-1:0] ry [0:N];
  logic signed [ROT_W-1:0] rz [0:N];
  side_t rside [0:N];

  logic signed [VW-1:0] xl [0:N];
  logic signed [VW-1:0] yl [0:N];
  logic signed [ROT_W-1:0] zl [0:N];
  logic signed [VW-1:0] xr [0:N];
  logic signed [VW-1:0] yr [0:N];
  logic signed [ROT_W-1:0] zr [0:N];
  side_t vside [0:N];
  logic signed [VW-1:0] y0;

  logic signed [ROT_W-1:0] raw_ext, clamped;
  side_t side0;
  logic signed [ROT_W-1:0] zl_c, zr_c, mag_l, mag_r;
  side_t fs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_base_mm <= '0;
      wheel_track_mm <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WHEEL_BASE: wheel_base_mm <= LENGTH_WIDTH'(cfg_data);
        REG_WHEEL_TRACK: wheel_track_mm <= LENGTH_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  // A stage moves when it is empty or the stage after it moves.
  genvar g;
  generate
    for (g = 0; g < NS - 1; g++) begin : g_en
      assign en[g] = !v[g] || en[g+1];
    end
  endgenerate
  assign en[NS-1] = !v[NS-1] || !wheel_stall;
  assign angle_stall = !en[0];
  assign wheel_valid = v[NS-1];

  // Input stage: clamp to the right angle and move to Q30.
  always_comb begin
    raw_ext = ROT_W'(center_angle);
    if (raw_ext > LIMIT) begin
      clamped = LIMIT;
    end else if (raw_ext < -LIMIT) begin
      clamped = -LIMIT;
    end else begin
      clamped = raw_ext;
    end
    side0 = '0;
    side0.raw = center_angle;
    side0.ok = (wheel_base_mm != '0);
    side0.bypass = (center_angle == '0) || (wheel_track_mm == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= angle_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rz[0] <= clamped <<< QS;
      rside[0] <= side0;
    end
  end

  assign rx[0] = CORDIC_X0;
  assign ry[0] = '0;

  generate
    for (g = 0; g < N; g++) begin : g_rot
      awas_rot_stage #(.SHIFT(g)) u_rot (
        .clk(clk), .rst(rst), .en(en[1+g]), .v_in(v[g]),
        .x_in(rx[g]), .y_in(ry[g]), .z_in(rz[g]), .side_in(rside[g]),
        .v_out(v[1+g]),
        .x_out(rx[g+1]), .y_out(ry[g+1]), .z_out(rz[g+1]), .side_out(rside[g+1])
      );
    end
  endgenerate

  awas_mul #(.LW(LENGTH_WIDTH), .VW(VW)) u_mul (
    .clk(clk), .rst(rst), .en_a(en[N+1]), .en_b(en[N+2]), .v_in(v[N]),
    .base(wheel_base_mm), .track(wheel_track_mm),
    .c_in(rx[N]), .s_in(ry[N]), .side_in(rside[N]),
    .v_a(v[N+1]), .v_b(v[N+2]),
    .xl_out(xl[0]), .xr_out(xr[0]), .y_out(y0), .side_out(vside[0])
  );

  assign yl[0] = y0;
  assign yr[0] = y0;
  assign zl[0] = '0;
  assign zr[0] = '0;

  generate
    for (g = 0; g < N; g++) begin : g_vec
      awas_vec_stage #(.SHIFT(g), .VW(VW)) u_vec (
        .clk(clk), .rst(rst), .en(en[N+3+g]), .v_in(v[N+2+g]),
        .xl_in(xl[g]), .yl_in(yl[g]), .zl_in(zl[g]),
        .xr_in(xr[g]), .yr_in(yr[g]), .zr_in(zr[g]), .side_in(vside[g]),
        .v_out(v[N+3+g]),
        .xl_out(xl[g+1]), .yl_out(yl[g+1]), .zl_out(zl[g+1]),
        .xr_out(xr[g+1]), .yr_out(yr[g+1]), .zr_out(zr[g+1]), .side_out(vside[g+1])
      );
    end
  endgenerate

  // Output stage: clamp to [0, pi/2], round half up, apply the sign.
  always_comb begin
    fs = vside[N];
    if (zl[N][ROT_W-1]) begin
      zl_c = '0;
    end else if (zl[N] > HALF_PI_Q30) begin
      zl_c = HALF_PI_Q30;
    end else begin
      zl_c = zl[N];
    end
    if (zr[N][ROT_W-1]) begin
      zr_c = '0;
    end else if (zr[N] > HALF_PI_Q30) begin
      zr_c = HALF_PI_Q30;
    end else begin
      zr_c = zr[N];
    end
    mag_l = (zl_c + ROUND) >>> QS;
    mag_r = (zr_c + ROUND) >>> QS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[NS-1] <= 1'b0;
    end else if (en[NS-1]) begin
      v[NS-1] <= v[NS-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      result_valid <= fs.ok;
      if (!fs.ok) begin
        left_angle <= '0;
        right_angle <= '0;
      end else if (fs.bypass) begin
        left_angle <= fs.raw;
        right_angle <= fs.raw;
      end else begin
        left_angle <= fs.dz_l ? ANGLE_W'(RIGHT_ANGLE)
                              : ANGLE_W'(fs.neg_l ? -mag_l : mag_l);
        right_angle <= fs.dz_r ? ANGLE_W'(RIGHT_ANGLE)
                               : ANGLE_W'(fs.neg_r ? -mag_r : mag_r);
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/awas_rot_stage.sv
// One registered stage of the rotation CORDIC that forms sine and cosine.
`default_nettype none
module awas_rot_stage #(
  parameter int SHIFT = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic v_in,
  input  wire logic signed [awas_pkg::ROT_W-1:0] x_in,
  input  wire logic signed [awas_pkg::ROT_W-1:0] y_in,
  input  wire logic signed [awas_pkg::ROT_W-1:0] z_in,
  input  awas_pkg::side_t side_in,
  output logic v_out,
  output logic signed [awas_pkg::ROT_W-1:0] x_out,
  output logic signed [awas_pkg::ROT_W-1:0] y_out,
  output logic signed [awas_pkg::ROT_W-1:0] z_out,
  output awas_pkg::side_t side_out
);
  import awas_pkg::*;

  localparam logic signed [ROT_W-1:0] STEP = atan_lut(SHIFT);

  logic signed [ROT_W-1:0] dx, dy;

  assign dx = y_in >>> SHIFT;
  assign dy = x_in >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      if (!z_in[ROT_W-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - STEP;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + STEP;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/awas_mul.sv
// Two stages that scale sine and cosine by the lengths and form both wheel ratios.
`default_nettype none
module awas_mul #(
  parameter int LW = 16,
  parameter int VW = LW + awas_pkg::ROT_W + 5
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en_a,
  input  wire logic en_b,
  input  wire logic v_in,
  input  wire logic [LW-1:0] base,
  input  wire logic [LW-1:0] track,
  input  wire logic signed [awas_pkg::ROT_W-1:0] c_in,
  input  wire logic signed [awas_pkg::ROT_W-1:0] s_in,
  input  awas_pkg::side_t side_in,
  output logic v_a,
  output logic v_b,
  output logic signed [VW-1:0] xl_out,
  output logic signed [VW-1:0] xr_out,
  output logic signed [VW-1:0] y_out,
  output awas_pkg::side_t side_out
);
  import awas_pkg::*;

  localparam int P = LW + ROT_W + 1;

  logic signed [P-1:0] lc, ls, ts;
  side_t side_a, side_b;
  logic signed [VW-1:0] num, lden, rden;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
    end else begin
      if (en_a) begin
        v_a <= v_in;
      end
      if (en_b) begin
        v_b <= v_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      lc <= $signed({1'b0, base}) * c_in;
      ls <= $signed({1'b0, base}) * s_in;
      ts <= $signed({1'b0, track}) * s_in;
      side_a <= side_in;
    end
  end

  always_comb begin
    num = VW'(ls) <<< 1;
    lden = (VW'(lc) <<< 1) - VW'(ts);
    rden = (VW'(lc) <<< 1) + VW'(ts);
    side_b = side_a;
    side_b.neg_l = num[VW-1] ^ lden[VW-1];
    side_b.neg_r = num[VW-1] ^ rden[VW-1];
    side_b.dz_l = (lden == '0);
    side_b.dz_r = (rden == '0);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      side_out <= side_b;
      xl_out <= lden[VW-1] ? -lden : lden;
      xr_out <= rden[VW-1] ? -rden : rden;
      y_out <= num[VW-1] ? -num : num;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/awas_vec_stage.sv
// One registered stage of the vectoring CORDIC, run for the left and right wheel.
`default_nettype none
module awas_vec_stage #(
  parameter int SHIFT = 0,
  parameter int VW = 55
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic v_in,
  input  wire logic signed [VW-1:0] xl_in,
  input  wire logic signed [VW-1:0] yl_in,
  input  wire logic signed [awas_pkg::ROT_W-1:0] zl_in,
  input  wire logic signed [VW-1:0] xr_in,
  input  wire logic signed [VW-1:0] yr_in,
  input  wire logic signed [awas_pkg::ROT_W-1:0] zr_in,
  input  awas_pkg::side_t side_in,
  output logic v_out,
  output logic signed [VW-1:0] xl_out,
  output logic signed [VW-1:0] yl_out,
  output logic signed [awas_pkg::ROT_W-1:0] zl_out,
  output logic signed [VW-1:0] xr_out,
  output logic signed [VW-1:0] yr_out,
  output logic signed [awas_pkg::ROT_W-1:0] zr_out,
  output awas_pkg::side_t side_out
);
  import awas_pkg::*;

  localparam logic signed [ROT_W-1:0] STEP = atan_lut(SHIFT);

  logic signed [VW-1:0] dxl, dyl, dxr, dyr;
  logic pl, pr;

  assign dxl = yl_in >>> SHIFT;
  assign dyl = xl_in >>> SHIFT;
  assign dxr = yr_in >>> SHIFT;
  assign dyr = xr_in >>> SHIFT;
  // Rotate toward the x axis while y is strictly positive.
  assign pl = !yl_in[VW-1] && (yl_in != '0);
  assign pr = !yr_in[VW-1] && (yr_in != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      xl_out <= pl ? xl_in + dxl : xl_in - dxl;
      yl_out <= pl ? yl_in - dyl : yl_in + dyl;
      zl_out <= pl ? zl_in + STEP : zl_in - STEP;
      xr_out <= pr ? xr_in + dxr : xr_in - dxr;
      yr_out <= pr ? yr_in - dyr : yr_in + dyr;
      zr_out <= pr ? zr_in + STEP : zr_in - STEP;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/awas_chk.sv
// Port checker for the wheel angle split block and its bind to the top level.
`default_nettype none
`include "ackermann_wheel_angle_split_defines.svh"
module awas_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic angle_valid,
  input wire logic angle_stall,
  input wire logic signed [15:0] center_angle,
  input wire logic wheel_valid,
  input wire logic wheel_stall,
  input wire logic signed [15:0] left_angle,
  input wire logic signed [15:0] right_angle,
  input wire logic result_valid,
  input wire logic cfg_valid,
  input wire logic cfg_ready,
  input wire logic [7:0] cfg_index,
  input wire logic [15:0] cfg_data
);
  // An empty output register means every stage can move.
  `AWAS_ASSERT(a_no_stall_when_empty, !wheel_valid |-> !angle_stall, "input stalled while output empty")
  // An unconfigured wheelbase gives zero angles.
  `AWAS_ASSERT(a_zero_when_invalid, wheel_valid && !result_valid |-> left_angle == 16'sd0 && right_angle == 16'sd0, "angles not zero without wheelbase")
  `AWAS_ASSERT(a_hold_result, wheel_valid && wheel_stall |=> wheel_valid, "stalled result dropped")
  `AWAS_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")
endmodule

bind ackermann_wheel_angle_split awas_chk u_awas_chk (.*);
`default_nettype wire

>>> tb/wheel_angle_checker.sv
// Checker for the wheel angle split block: predicts wheel angles and compares transfers.
`timescale 1ns / 1ps
module wheel_angle_checker (
  input  logic clk,
  input  logic rst,
  input  logic angle_valid,
  input  logic angle_stall,
  input  logic signed [awas_pkg::ANGLE_W-1:0] center_angle,
  input  logic wheel_valid,
  input  logic wheel_stall,
  input  logic signed [awas_pkg::ANGLE_W-1:0] left_angle,
  input  logic signed [awas_pkg::ANGLE_W-1:0] right_angle,
  input  logic result_valid,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [awas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [awas_pkg::CFG_DATA_W-1:0] cfg_data,
  output int errors,
  output int pending
);
  import awas_pkg::*;

  localparam int FRAC = 14;
  localparam int STAGES = 16;
  localparam int SHIFT = 30 - FRAC;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic ok;
  } wheel_pair_t;

  wheel_pair_t wheel_q[$];
  longint base_len, track_len;

  function automatic longint atan_step(int i);
    longint t[16] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                      131072, 65536, 32768};
    return t[i];
  endfunction

  // Arithmetic shift that rounds toward minus infinity.
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint to_angle(longint z);
    if (z < 0) z = 0;
    if (z > 64'sd1686629713) z = 64'sd1686629713;
    return (z + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
  endfunction

  function automatic longint wheel_of(longint num, longint den);
    longint x, y, z, dx, dy, mag;
    logic neg;
    if (den == 0) return to_angle(64'sd1686629713);
    neg = (num < 0) != (den < 0);
    x = den < 0 ? -den : den;
    y = num < 0 ? -num : num;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    mag = to_angle(z);
    return neg ? -mag : mag;
  endfunction

  function automatic wheel_pair_t split_angle(logic signed [15:0] ca);
    wheel_pair_t r;
    longint a, lim, x, y, z, dx, dy, num;
    r = '0;
    if (base_len == 0) return r;
    r.ok = 1'b1;
    if (ca == 0 || track_len == 0) begin
      r.left = ca;
      r.right = ca;
      return r;
    end
    lim = 64'sd1686629713 >>> SHIFT;
    a = ca;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    x = 64'sd1 <<< 29; y = 0; z = a <<< SHIFT;
    for (int i = 0; i < STAGES; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    num = 2 * base_len * y;
    r.left = 16'(wheel_of(num, 2 * base_len * x - track_len * y));
    r.right = 16'(wheel_of(num, 2 * base_len * x + track_len * y));
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    errors++;
  endtask

  assign pending = wheel_q.size();

  always @(posedge clk) begin
    wheel_pair_t w;
    if (rst) begin
      base_len = 0;
      track_len = 0;
      errors = 0;
      wheel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WHEEL_BASE) base_len = cfg_data;
        else if (cfg_index == REG_WHEEL_TRACK) track_len = cfg_data;
      end
      if (angle_valid && !angle_stall) wheel_q.push_back(split_angle(center_angle));
      if (wheel_valid && !wheel_stall) begin
        if (wheel_q.size() == 0) begin
          $display("mismatch: unexpected transfer at %0t", $realtime);
          errors++;
        end else begin
          w = wheel_q.pop_front();
          if (left_angle !== w.left) report("left_angle", left_angle, w.left);
          if (right_angle !== w.right) report("right_angle", right_angle, w.right);
          if (result_valid !== w.ok) report("result_valid", 16'(result_valid), 16'(w.ok));
        end
      end
    end
  end
endmodule

>>> tb/tb.sv
// Testbench top: stimulus, configuration phases and verdict for the wheel angle split.
`timescale 1ns / 1ps
module tb;
  import awas_pkg::*;

  localparam int LATENCY = 2 * 16 + 4;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic angle_valid = 1'b0, angle_stall;
  logic signed [ANGLE_W-1:0] center_angle = '0;
  logic wheel_valid, wheel_stall = 1'b0;
  logic signed [ANGLE_W-1:0] left_angle, right_angle;
  logic result_valid;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int errors, pending;
  int quiet_cycles = 0;
  logic calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ackermann_wheel_angle_split dut (.*);

  wheel_angle_checker chk (.*);

  // Receiver stalls at random except in the calm stretch.
  always @(posedge clk) wheel_stall <= !calm && ($urandom_range(99) < 12);

  always @(posedge clk) begin
    if ((angle_valid && !angle_stall) || (wheel_valid && !wheel_stall)
        || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("FAIL ackermann_wheel_angle_split");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_angle(logic signed [15:0] a);
    while (!calm && $urandom_range(99) < 12) begin
      angle_valid <= 1'b0;
      @(posedge clk);
    end
    angle_valid <= 1'b1;
    center_angle <= a;
    do @(posedge clk); while (angle_stall);
  endtask

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(60)) - 30);
      2: return $urandom_range(1) ? 16'sd25735 : -16'sd25735;
      default: return 16'(int'($urandom_range(51470)) - 25735);
    endcase
  endfunction

  task automatic phase(logic [15:0] lb, logic [15:0] lt, int n);
    drain();
    write_reg(REG_WHEEL_BASE, lb);
    write_reg(REG_WHEEL_TRACK, lt);
    for (int i = 0; i < n; i++) send_angle(pick_angle());
    angle_valid <= 1'b0;
  endtask

  logic signed [15:0] directed[] = '{16'sd0, 16'sd1, -16'sd1, 16'sd25735, -16'sd25735,
    16'sd32767, -16'sd32768, 16'sd12868, -16'sd12868, 16'sd100, 16'sd8000, -16'sd20000};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Unconfigured wheelbase first.
    foreach (directed[i]) send_angle(directed[i]);
    angle_valid <= 1'b0;
    drain();
    write_reg(REG_WHEEL_BASE, 16'd2700);
    write_reg(REG_WHEEL_TRACK, 16'd1600);
    foreach (directed[i]) send_angle(directed[i]);
    angle_valid <= 1'b0;
    phase(16'd2700, 16'd1600, 400);
    phase(16'd65535, 16'd65535, 200);
    phase(16'd1, 16'd65535, 200);
    phase(16'd65535, 16'd1, 150);
    // Track of twice the wheelbase hits a zero wheel radius at pi/4.
    phase(16'd1000, 16'd2000, 20);
    for (int i = 0; i < 20; i++) send_angle($urandom_range(1) ? 16'sd12868 : -16'sd12868);
    angle_valid <= 1'b0;
    phase(16'd3000, 16'd0, 150);
    calm <= 1'b1;
    phase(16'($urandom_range(65535)), 16'($urandom_range(65535)), 300);
    calm <= 1'b0;
    phase(16'd0, 16'd1500, 100);
    phase(16'($urandom_range(65535)), 16'($urandom_range(65535)), 250);
    drain();
    if (errors == 0) $display("PASS ackermann_wheel_angle_split");
    else $display("FAIL ackermann_wheel_angle_split");
    $finish;
  end
endmodule
